FILE: src/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// shared types, constants and control words for the bounded array list
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_INSERT       = 3'd1,
        OP_REMOVE_AT    = 3'd2,
        OP_REMOVE_MATCH = 3'd3,
        OP_CLEAR        = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [5:0]          position;
        logic signed [31:0]  value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  removed_value;
        logic                found;
        logic [5:0]          length;
    } out_item_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_LOAD_COUNT,
        CUR_LOAD_POS,
        CUR_ZERO
    } cur_load_t;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_INC,
        STEP_DEC
    } step_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_ZERO
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_CUR_M1,
        RD_CUR_P1
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_UP,
        S_PUT,
        S_HEAD,
        S_HEAD_WAIT,
        S_SHIFT_DN,
        S_SCAN,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       pos_to_count;
        cur_load_t  cur_load;
        step_t      cur_step;
        cnt_op_t    cnt_op;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       mov_en;
        logic       put_en;
        logic       st_en;
        status_t    st_code;
        logic       found_set;
        logic       take_removed;
        logic       out_load;
    } bal_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       full;
        logic       pos_gt_count;
        logic       pos_ge_count;
        logic       cur_gt_pos;
        logic       cur_lt_count;
        logic       cur_next_lt_count;
        logic       match;
        logic       out_busy;
    } bal_sts_t;

endpackage

FILE: src/bal_datapath.sv
// ----------------------------------------------------------------------------
// bal_datapath
// entry memory, length counter, cursor and result registers of the list
// ----------------------------------------------------------------------------
module bal_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  bal_pkg::in_item_t s_item,
    input  logic              m_ready,
    output logic              m_valid,
    output bal_pkg::out_item_t m_item,
    input  bal_pkg::bal_cmd_t cmd,
    output bal_pkg::bal_sts_t sts
);
    import bal_pkg::*;

    data_t      mem [CAPACITY];

    logic [2:0] op_reg;
    logic [5:0] pos_reg;
    data_t      val_reg;
    cnt_t       count_reg, count_next;
    cnt_t       cur_reg, cur_next;
    data_t      rd_data_reg;
    logic       rd_vld_reg;
    logic       mv_pend_reg;
    idx_t       mv_addr_reg;
    status_t    status_reg;
    data_t      removed_reg;
    logic       found_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;

    cnt_t       cur_m1, cur_p1;
    idx_t       rd_addr;

    assign cur_m1 = cur_reg - CNT_W'(1);
    assign cur_p1 = cur_reg + CNT_W'(1);

    always_comb begin
        unique case (cmd.rd_sel)
            RD_CUR_M1: rd_addr = cur_m1[IDX_W-1:0];
            RD_CUR_P1: rd_addr = cur_p1[IDX_W-1:0];
            default:   rd_addr = cur_reg[IDX_W-1:0];
        endcase
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mv_pend_reg) begin
            mem[mv_addr_reg] <= rd_data_reg;
        end else if (cmd.put_en) begin
            mem[cur_reg[IDX_W-1:0]] <= val_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        unique case (cmd.cur_load)
            CUR_LOAD_COUNT: cur_next = count_reg;
            CUR_LOAD_POS:   cur_next = pos_reg;
            CUR_ZERO:       cur_next = '0;
            default: begin
                unique case (cmd.cur_step)
                    STEP_INC: cur_next = cur_p1;
                    STEP_DEC: cur_next = cur_m1;
                    default:  cur_next = cur_reg;
                endcase
            end
        endcase
    end

    always_comb begin
        unique case (cmd.cnt_op)
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = count_reg - CNT_W'(1);
            CNT_ZERO: count_next = '0;
            default:  count_next = count_reg;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            mv_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            rd_vld_reg    <= cmd.rd_en;
            mv_pend_reg   <= cmd.mov_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (cmd.mov_en) begin
            mv_addr_reg <= cur_reg[IDX_W-1:0];
        end
        if (cmd.load) begin
            op_reg      <= s_item.opcode;
            pos_reg     <= s_item.position;
            val_reg     <= s_item.value[DATA_WIDTH-1:0];
            status_reg  <= ST_OK;
            removed_reg <= '0;
            found_reg   <= 1'b0;
        end else begin
            if (cmd.pos_to_count) begin
                pos_reg <= count_reg;
            end
            if (cmd.st_en) begin
                status_reg <= cmd.st_code;
            end
            if (cmd.take_removed) begin
                removed_reg <= rd_data_reg;
            end
            if (cmd.found_set) begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_reg.status        <= status_reg;
            out_reg.removed_value <= $signed(removed_reg);
            out_reg.found         <= found_reg;
            out_reg.length        <= count_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    assign sts.opcode            = op_reg;
    assign sts.full              = (count_reg == CNT_W'(CAPACITY));
    assign sts.pos_gt_count      = (pos_reg > count_reg);
    assign sts.pos_ge_count      = (pos_reg >= count_reg);
    assign sts.cur_gt_pos        = (cur_reg > pos_reg);
    assign sts.cur_lt_count      = (cur_reg < count_reg);
    assign sts.cur_next_lt_count = ({1'b0, cur_reg} + (CNT_W+1)'(1)) < {1'b0, count_reg};
    assign sts.match             = rd_vld_reg && (rd_data_reg == val_reg);
    assign sts.out_busy          = out_valid_reg && !m_ready;

    // length stays within capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("length above capacity");

    // a pending shift write and a value write never compete for the port
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mv_pend_reg && cmd.put_en))
        else $error("two memory writes in one cycle");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(out_valid_reg && !m_ready))
        else $error("output register overwritten");

    // length moves by one at most, or drops to zero
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1) ||
             count_reg == '0))
        else $error("length jumped");

endmodule

FILE: src/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl
// sequencer for the list operations: decision, shift and scan loops
// ----------------------------------------------------------------------------
module bal_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bal_pkg::bal_sts_t sts,
    output bal_pkg::bal_cmd_t cmd
);
    import bal_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (sts.opcode)
                    OP_APPEND:       state_next = sts.full ? S_FINISH : S_SHIFT_UP;
                    OP_INSERT:       state_next = (sts.pos_gt_count || sts.full) ?
                                                  S_FINISH : S_SHIFT_UP;
                    OP_REMOVE_AT:    state_next = sts.pos_ge_count ? S_FINISH : S_HEAD;
                    OP_REMOVE_MATCH: state_next = S_SCAN;
                    default:         state_next = S_FINISH;
                endcase
            end
            S_SHIFT_UP: begin
                if (!sts.cur_gt_pos) begin
                    state_next = S_PUT;
                end
            end
            S_PUT:       state_next = S_FINISH;
            S_HEAD:      state_next = S_HEAD_WAIT;
            S_HEAD_WAIT: state_next = S_SHIFT_DN;
            S_SHIFT_DN: begin
                if (!sts.cur_next_lt_count) begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN: begin
                priority if (sts.match) begin
                    state_next = S_SHIFT_DN;
                end else if (!sts.cur_lt_count) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd              = '0;
        cmd.cur_load     = CUR_HOLD;
        cmd.cur_step     = STEP_NONE;
        cmd.cnt_op       = CNT_HOLD;
        cmd.rd_sel       = RD_CUR;
        cmd.st_code      = ST_OK;
        s_ready          = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_DECIDE: begin
                unique case (sts.opcode)
                    OP_APPEND: begin
                        if (sts.full) begin
                            cmd.st_en   = 1'b1;
                            cmd.st_code = ST_FULL;
                        end else begin
                            cmd.cur_load     = CUR_LOAD_COUNT;
                            cmd.pos_to_count = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        priority if (sts.pos_gt_count) begin
                            cmd.st_en   = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end else if (sts.full) begin
                            cmd.st_en   = 1'b1;
                            cmd.st_code = ST_FULL;
                        end else begin
                            cmd.cur_load = CUR_LOAD_COUNT;
                        end
                    end
                    OP_REMOVE_AT: begin
                        if (sts.pos_ge_count) begin
                            cmd.st_en   = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end else begin
                            cmd.cur_load = CUR_LOAD_POS;
                        end
                    end
                    OP_REMOVE_MATCH: cmd.cur_load = CUR_ZERO;
                    OP_CLEAR:        cmd.cnt_op   = CNT_ZERO;
                    default: ;
                endcase
            end
            S_SHIFT_UP: begin
                if (sts.cur_gt_pos) begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_CUR_M1;
                    cmd.mov_en   = 1'b1;
                    cmd.cur_step = STEP_DEC;
                end
            end
            S_PUT: begin
                cmd.put_en = 1'b1;
                cmd.cnt_op = CNT_INC;
            end
            S_HEAD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
            end
            S_HEAD_WAIT: cmd.take_removed = 1'b1;
            S_SHIFT_DN: begin
                if (sts.cur_next_lt_count) begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_CUR_P1;
                    cmd.mov_en   = 1'b1;
                    cmd.cur_step = STEP_INC;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            S_SCAN: begin
                priority if (sts.match) begin
                    cmd.found_set = 1'b1;
                    cmd.cur_step  = STEP_DEC;
                end else if (sts.cur_lt_count) begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_CUR;
                    cmd.cur_step = STEP_INC;
                end
            end
            S_FINISH: cmd.out_load = !sts.out_busy;
            default: ;
        endcase
    end

endmodule

FILE: src/bounded_array_list.sv
// ----------------------------------------------------------------------------
// bounded_array_list
// fixed-capacity ordered list with append, insert, remove-at,
// remove-first-match and clear, one result transaction per request
// ----------------------------------------------------------------------------
//
//  channel   ports                      direction  payload
//  --------  -------------------------  ---------  ---------------------------------
//  request   s_valid s_ready s_item     in         opcode, position, value
//  result    m_valid m_ready m_item     out        status, removed_value, found, length
//
//  operations: one request at a time; insert and remove-at shift the entries
//    between position and length, one entry moved per cycle through the
//    single-write, registered-read entry memory, and remove-first-match scans
//    and shifts down in one pass over the list; the result is loaded into the
//    output register when the sequencer leaves its finish step
//  reset: synchronous active-low aresetn empties the list; entry contents are
//    not cleared, only entries below the length are ever read
//  stalls: the result sits in an output register, so a new request is taken
//    while the previous result waits for m_ready; a finished operation holds
//    in its last step only when the output register is still occupied
//
module bounded_array_list (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  bal_pkg::in_item_t  s_item,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output bal_pkg::out_item_t m_item
);
    import bal_pkg::*;

    // command and status between sequencer and datapath
    bal_cmd_t cmd;
    bal_sts_t sts;

    // sequencer: decision, shift loops, scan loop and result hand-off
    bal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: entry memory, length, cursor, result and output registers
    bal_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
